// File: src/prt_pkg.sv
package prt_pkg;

  // Default sizes of the table.
  localparam int unsigned ENTRIES_DEFAULT      = 16;
  localparam int unsigned HANDLE_WIDTH_DEFAULT = 16;

  // Fixed field widths.
  localparam int unsigned SEQ_WIDTH = 32;
  localparam int unsigned OP_WIDTH  = 3;

  // Operation codes. The two unused codes behave as a query.
  typedef enum logic [OP_WIDTH-1:0] {
    OP_BEGIN_WAIT      = 3'd0,
    OP_STORE_REPLY     = 3'd1,
    OP_TAKE_REPLY      = 3'd2,
    OP_ERASE           = 3'd3,
    OP_RECONNECT_CLEAR = 3'd4,
    OP_QUERY           = 3'd5
  } op_e;

  // Lookup summary that the match logic hands to the table update.
  typedef struct packed {
    logic found;      // one valid entry carries the key
    logic ready;      // that entry holds a reply
    logic failed;     // that entry carries the failed mark
    logic any_free;   // at least one slot is unused
    logic any_valid;  // at least one slot is in use
  } match_t;

  // Result flags of one item.
  typedef struct packed {
    logic accepted;
    logic entry_found;
    logic entry_ready;
    logic entry_failed;
    logic entry_waiting;
    logic table_full;
  } flags_t;

endpackage

// File: src/pending_reply_tracker.sv
// Channel  Handshake               Payload
// -------  ----------------------  --------------------------------------------
// in       in_valid_i / in_stall_o  operation_i, sequence_number_i, reply_in_i
// out      out_valid_o / out_stall_i accepted_o, entry_*_o, reply_out_o,
//                                     table_full_o
//
// One item per cycle while the result side does not stall.
// The table lookup and update sit between the input register and the result
// register, so each item sees every table change of the item before it.
// Reset clears the slot flags at once; no clearing pass is needed.
// A stalled result holds the input register, and input stalls only then.
module pending_reply_tracker import prt_pkg::*; #(
  parameter int unsigned ENTRIES      = ENTRIES_DEFAULT,
  parameter int unsigned HANDLE_WIDTH = HANDLE_WIDTH_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_WIDTH-1:0]     operation_i,
  input  logic [SEQ_WIDTH-1:0]    sequence_number_i,
  input  logic [HANDLE_WIDTH-1:0] reply_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    accepted_o,
  output logic                    entry_found_o,
  output logic                    entry_ready_o,
  output logic                    entry_failed_o,
  output logic                    entry_waiting_o,
  output logic [HANDLE_WIDTH-1:0] reply_out_o,
  output logic                    table_full_o
);

  logic                    in_valid_q, in_valid_d;
  logic [OP_WIDTH-1:0]     op_q;
  logic [SEQ_WIDTH-1:0]    key_q;
  logic [HANDLE_WIDTH-1:0] handle_q;
  logic                    out_valid_q, out_valid_d;
  flags_t                  flags_q;
  logic [HANDLE_WIDTH-1:0] reply_q;
  flags_t                  flags;
  logic [HANDLE_WIDTH-1:0] reply;
  logic                    advance;
  logic                    load;

  // The held item moves on when the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  // Lookup and update of the table for the held item.
  prt_table #(
    .ENTRIES      (ENTRIES),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (advance),
    .op_i     (op_q),
    .key_i    (key_q),
    .handle_i (handle_q),
    .flags_o  (flags),
    .reply_o  (reply)
  );

  // Valid bits of both registers.
  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q     <= operation_i;
      key_q    <= sequence_number_i;
      handle_q <= reply_in_i;
    end
    if (advance) begin
      flags_q <= flags;
      reply_q <= reply;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = flags_q.accepted;
  assign entry_found_o   = flags_q.entry_found;
  assign entry_ready_o   = flags_q.entry_ready;
  assign entry_failed_o  = flags_q.entry_failed;
  assign entry_waiting_o = flags_q.entry_waiting;
  assign reply_out_o     = reply_q;
  assign table_full_o    = flags_q.table_full;

`ifndef SYNTHESIS
  // Input only stalls while an item is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> in_valid_q)
    else $error("pending_reply_tracker: stall without a held item");

  // Every processed item leaves a result behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni) advance |=> out_valid_q)
    else $error("pending_reply_tracker: processed item lost");

  // A begin wait that meets a full table is never reported as accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(table_full_o && accepted_o))
    else $error("pending_reply_tracker: full and accepted together");

  // Without a matching entry no entry flag and no reply are reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !entry_found_o) |->
      (!entry_ready_o && !entry_failed_o && !entry_waiting_o && reply_out_o == '0))
    else $error("pending_reply_tracker: entry flags without a match");
`endif

endmodule

// File: src/prt_match.sv
module prt_match import prt_pkg::*; #(
  parameter int unsigned ENTRIES      = ENTRIES_DEFAULT,
  parameter int unsigned HANDLE_WIDTH = HANDLE_WIDTH_DEFAULT
) (
  input  logic [SEQ_WIDTH-1:0]    key_i,
  input  logic [ENTRIES-1:0]      valid_i,
  input  logic [ENTRIES-1:0]      ready_i,
  input  logic [ENTRIES-1:0]      failed_i,
  input  logic [SEQ_WIDTH-1:0]    tag_i   [ENTRIES],
  input  logic [HANDLE_WIDTH-1:0] reply_i [ENTRIES],
  output logic [ENTRIES-1:0]      hit_vec_o,
  output logic [ENTRIES-1:0]      first_free_o,
  output logic [HANDLE_WIDTH-1:0] hit_reply_o,
  output match_t                  match_o
);

  logic [ENTRIES-1:0]      free_vec;
  logic [HANDLE_WIDTH-1:0] reply_acc;

  // Compare the key against every tag in parallel; invalid slots never hit.
  always_comb begin
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      hit_vec_o[i] = valid_i[i] && (tag_i[i] == key_i);
    end
  end

  // Lowest unused slot as a one-hot vector.
  assign free_vec     = ~valid_i;
  assign first_free_o = free_vec & ((~free_vec) + ENTRIES'(1));

  // Tags are unique, so at most one slot hits and an OR picks its reply.
  always_comb begin
    reply_acc = '0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      if (hit_vec_o[i] && ready_i[i]) begin
        reply_acc = reply_acc | reply_i[i];
      end
    end
  end

  assign hit_reply_o       = reply_acc;
  assign match_o.found     = |hit_vec_o;
  assign match_o.ready     = |(hit_vec_o & ready_i);
  assign match_o.failed    = |(hit_vec_o & failed_i);
  assign match_o.any_free  = |free_vec;
  assign match_o.any_valid = |valid_i;

endmodule

// File: src/prt_table.sv
module prt_table import prt_pkg::*; #(
  parameter int unsigned ENTRIES      = ENTRIES_DEFAULT,
  parameter int unsigned HANDLE_WIDTH = HANDLE_WIDTH_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    go_i,
  input  logic [OP_WIDTH-1:0]     op_i,
  input  logic [SEQ_WIDTH-1:0]    key_i,
  input  logic [HANDLE_WIDTH-1:0] handle_i,
  output flags_t                  flags_o,
  output logic [HANDLE_WIDTH-1:0] reply_o
);

  logic [ENTRIES-1:0]      valid_q, valid_d;
  logic [ENTRIES-1:0]      ready_q, ready_d;
  logic [ENTRIES-1:0]      failed_q, failed_d;
  logic [SEQ_WIDTH-1:0]    tag_q   [ENTRIES];
  logic [HANDLE_WIDTH-1:0] reply_q [ENTRIES];
  logic [ENTRIES-1:0]      tag_we;
  logic [ENTRIES-1:0]      reply_we;
  logic [HANDLE_WIDTH-1:0] reply_wdata;
  logic [ENTRIES-1:0]      hit_vec;
  logic [ENTRIES-1:0]      first_free;
  logic [HANDLE_WIDTH-1:0] hit_reply;
  match_t                  match;
  op_e                     op;

  assign op = op_e'(op_i);

  // Associative lookup against the current table contents.
  prt_match #(
    .ENTRIES      (ENTRIES),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_match (
    .key_i        (key_i),
    .valid_i      (valid_q),
    .ready_i      (ready_q),
    .failed_i     (failed_q),
    .tag_i        (tag_q),
    .reply_i      (reply_q),
    .hit_vec_o    (hit_vec),
    .first_free_o (first_free),
    .hit_reply_o  (hit_reply),
    .match_o      (match)
  );

  // The stored handle takes the input handle only on store reply; begin wait zeroes it.
  assign reply_wdata = (op == OP_STORE_REPLY) ? handle_i : '0;

  // Per-slot update for the operation of the current item.
  always_comb begin
    valid_d  = valid_q;
    ready_d  = ready_q;
    failed_d = failed_q;
    tag_we   = '0;
    reply_we = '0;
    if (go_i) begin
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        unique case (op)
          OP_BEGIN_WAIT: begin
            if (!match.found && first_free[i]) begin
              valid_d[i]  = 1'b1;
              ready_d[i]  = 1'b0;
              failed_d[i] = 1'b0;
              tag_we[i]   = 1'b1;
              reply_we[i] = 1'b1;
            end else if (hit_vec[i] && !ready_q[i]) begin
              failed_d[i] = 1'b0;
              reply_we[i] = 1'b1;
            end
          end
          OP_STORE_REPLY: begin
            if (hit_vec[i] && !ready_q[i]) begin
              ready_d[i]  = 1'b1;
              reply_we[i] = 1'b1;
            end
          end
          OP_TAKE_REPLY: begin
            if (hit_vec[i] && ready_q[i]) begin
              valid_d[i]  = 1'b0;
              ready_d[i]  = 1'b0;
              failed_d[i] = 1'b0;
            end
          end
          OP_ERASE: begin
            if (hit_vec[i]) begin
              valid_d[i]  = 1'b0;
              ready_d[i]  = 1'b0;
              failed_d[i] = 1'b0;
            end
          end
          OP_RECONNECT_CLEAR: begin
            if (valid_q[i] && ready_q[i]) begin
              valid_d[i]  = 1'b0;
              ready_d[i]  = 1'b0;
              failed_d[i] = 1'b0;
            end else if (valid_q[i]) begin
              failed_d[i] = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result flags report the entry as it was before the update.
  always_comb begin
    flags_o               = '0;
    flags_o.entry_found   = match.found;
    flags_o.entry_ready   = match.ready;
    flags_o.entry_failed  = match.failed;
    flags_o.entry_waiting = match.found && !match.ready && !match.failed;
    unique case (op)
      OP_BEGIN_WAIT: begin
        flags_o.accepted   = match.found ? !match.ready : match.any_free;
        flags_o.table_full = !match.found && !match.any_free;
      end
      OP_STORE_REPLY:     flags_o.accepted = match.found && !match.ready;
      OP_TAKE_REPLY:      flags_o.accepted = match.found && match.ready;
      OP_ERASE:           flags_o.accepted = match.found;
      OP_RECONNECT_CLEAR: flags_o.accepted = match.any_valid;
      default:            flags_o.accepted = 1'b0;
    endcase
  end

  assign reply_o = hit_reply;

  // Slot flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      ready_q  <= '0;
      failed_q <= '0;
    end else begin
      valid_q  <= valid_d;
      ready_q  <= ready_d;
      failed_q <= failed_d;
    end
  end

  // Tags are only read while the slot is valid, handles only while it is also ready.
  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      if (tag_we[i]) begin
        tag_q[i] <= key_i;
      end
      if (reply_we[i]) begin
        reply_q[i] <= reply_wdata;
      end
    end
  end

`ifndef SYNTHESIS
  // A key never matches more than one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit_vec))
    else $error("prt_table: key matches several slots");

  // Ready and failed marks only live on valid slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ready_q | failed_q) & ~valid_q) == '0)
    else $error("prt_table: mark set on an unused slot");
`endif

endmodule

// File: tb/reply_table_checker.sv
module reply_table_checker import prt_pkg::*; #(
  parameter int unsigned ENTRIES      = ENTRIES_DEFAULT,
  parameter int unsigned HANDLE_WIDTH = HANDLE_WIDTH_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [OP_WIDTH-1:0]     operation_i,
  input  logic [SEQ_WIDTH-1:0]    sequence_number_i,
  input  logic [HANDLE_WIDTH-1:0] reply_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic                    accepted_i,
  input  logic                    entry_found_i,
  input  logic                    entry_ready_i,
  input  logic                    entry_failed_i,
  input  logic                    entry_waiting_i,
  input  logic [HANDLE_WIDTH-1:0] reply_out_i,
  input  logic                    table_full_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      checked_o,
  output int                      full_seen_o
);

  // Flags and handle that one lookup is expected to report.
  typedef struct packed {
    logic                    accepted;
    logic                    found;
    logic                    ready;
    logic                    failed;
    logic                    waiting;
    logic [HANDLE_WIDTH-1:0] reply;
    logic                    full;
  } lookup_report_t;

  // Shadow copy of the request table.
  logic                    entry_used      [ENTRIES];
  logic [SEQ_WIDTH-1:0]    entry_key       [ENTRIES];
  logic                    entry_has_reply [ENTRIES];
  logic                    entry_lost      [ENTRIES];
  logic [HANDLE_WIDTH-1:0] entry_handle    [ENTRIES];

  lookup_report_t expected_reports[$];
  int mismatch_count = 0;
  int checked_count  = 0;
  int full_count     = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Applies one item to the shadow table and returns what the block must report.
  task automatic predict_lookup(input logic [OP_WIDTH-1:0] op,
                                input logic [SEQ_WIDTH-1:0] key,
                                input logic [HANDLE_WIDTH-1:0] handle,
                                output lookup_report_t rpt);
    int hit;
    int free_slot;
    hit = -1;
    free_slot = -1;
    rpt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (entry_used[i] && entry_key[i] == key && hit < 0) hit = i;
      if (!entry_used[i] && free_slot < 0) free_slot = i;
    end

    // Flags are those of the matching entry before the update.
    if (hit >= 0) begin
      rpt.found   = 1'b1;
      rpt.ready   = entry_has_reply[hit];
      rpt.failed  = entry_lost[hit];
      rpt.waiting = !entry_has_reply[hit] && !entry_lost[hit];
      if (entry_has_reply[hit]) rpt.reply = entry_handle[hit];
    end

    case (op)
      OP_BEGIN_WAIT: begin
        if (hit < 0) begin
          if (free_slot < 0) begin
            rpt.full = 1'b1;
          end else begin
            entry_used[free_slot]      = 1'b1;
            entry_key[free_slot]       = key;
            entry_has_reply[free_slot] = 1'b0;
            entry_lost[free_slot]      = 1'b0;
            entry_handle[free_slot]    = '0;
            rpt.accepted = 1'b1;
          end
        end else if (!entry_has_reply[hit]) begin
          entry_lost[hit]   = 1'b0;
          entry_handle[hit] = '0;
          rpt.accepted = 1'b1;
        end
      end
      OP_STORE_REPLY: begin
        if (hit >= 0 && !entry_has_reply[hit]) begin
          entry_handle[hit]    = handle;
          entry_has_reply[hit] = 1'b1;
          rpt.accepted = 1'b1;
        end
      end
      OP_TAKE_REPLY: begin
        if (hit >= 0 && entry_has_reply[hit]) begin
          entry_used[hit]      = 1'b0;
          entry_has_reply[hit] = 1'b0;
          entry_lost[hit]      = 1'b0;
          rpt.accepted = 1'b1;
        end
      end
      OP_ERASE: begin
        if (hit >= 0) begin
          entry_used[hit]      = 1'b0;
          entry_has_reply[hit] = 1'b0;
          entry_lost[hit]      = 1'b0;
          rpt.accepted = 1'b1;
        end
      end
      OP_RECONNECT_CLEAR: begin
        // Answered entries are dropped, unanswered ones are marked failed.
        for (int i = 0; i < ENTRIES; i++) begin
          if (entry_used[i]) begin
            rpt.accepted = 1'b1;
            if (entry_has_reply[i]) begin
              entry_used[i]      = 1'b0;
              entry_has_reply[i] = 1'b0;
              entry_lost[i]      = 1'b0;
            end else begin
              entry_lost[i] = 1'b1;
            end
          end
        end
      end
      default: begin
        // Query and the spare codes leave the table alone.
      end
    endcase
  endtask

  task automatic compare_result(input lookup_report_t want);
    if (accepted_i !== want.accepted)
      report_mismatch("accepted", 64'(accepted_i), 64'(want.accepted));
    if (entry_found_i !== want.found)
      report_mismatch("entry_found", 64'(entry_found_i), 64'(want.found));
    if (entry_ready_i !== want.ready)
      report_mismatch("entry_ready", 64'(entry_ready_i), 64'(want.ready));
    if (entry_failed_i !== want.failed)
      report_mismatch("entry_failed", 64'(entry_failed_i), 64'(want.failed));
    if (entry_waiting_i !== want.waiting)
      report_mismatch("entry_waiting", 64'(entry_waiting_i), 64'(want.waiting));
    if (reply_out_i !== want.reply)
      report_mismatch("reply_out", 64'(reply_out_i), 64'(want.reply));
    if (table_full_i !== want.full)
      report_mismatch("table_full", 64'(table_full_i), 64'(want.full));
    checked_count++;
  endtask

  // Both channels are sampled at the clock edge, before any driver update lands.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    lookup_report_t rpt;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_used[i]      = 1'b0;
        entry_key[i]       = '0;
        entry_has_reply[i] = 1'b0;
        entry_lost[i]      = 1'b0;
        entry_handle[i]    = '0;
      end
      expected_reports.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_lookup(operation_i, sequence_number_i, reply_in_i, rpt);
        expected_reports.push_back(rpt);
        if (rpt.full) full_count++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0)
          report_mismatch("result with no item outstanding", 64'd1, 64'd0);
        else
          compare_result(expected_reports.pop_front());
      end
    end
    pending_o    <= expected_reports.size();
    fail_count_o <= mismatch_count;
    checked_o    <= checked_count;
    full_seen_o  <= full_count;
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  import prt_pkg::*;

  localparam int unsigned HW = HANDLE_WIDTH_DEFAULT;
  localparam int unsigned KEY_POOL = 24;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned DRAIN_LIMIT = 5000;

  // Codes the block does not define; they must behave as a query.
  localparam logic [OP_WIDTH-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_WIDTH-1:0] OP_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_WIDTH-1:0]   operation = OP_QUERY;
  logic [SEQ_WIDTH-1:0]  sequence_number = '0;
  logic [HW-1:0]         reply_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  accepted;
  logic                  entry_found;
  logic                  entry_ready;
  logic                  entry_failed;
  logic                  entry_waiting;
  logic [HW-1:0]         reply_out;
  logic                  table_full;

  int fail_count;
  int pending;
  int checked;
  int full_seen;

  int items_sent = 0;
  int quiet_items = 0;
  logic [SEQ_WIDTH-1:0] key_pool [KEY_POOL];

  pending_reply_tracker DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .operation_i       (operation),
    .sequence_number_i (sequence_number),
    .reply_in_i        (reply_in),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .accepted_o        (accepted),
    .entry_found_o     (entry_found),
    .entry_ready_o     (entry_ready),
    .entry_failed_o    (entry_failed),
    .entry_waiting_o   (entry_waiting),
    .reply_out_o       (reply_out),
    .table_full_o      (table_full)
  );

  reply_table_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .operation_i       (operation),
    .sequence_number_i (sequence_number),
    .reply_in_i        (reply_in),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .accepted_i        (accepted),
    .entry_found_i     (entry_found),
    .entry_ready_i     (entry_ready),
    .entry_failed_i    (entry_failed),
    .entry_waiting_i   (entry_waiting),
    .reply_out_i       (reply_out),
    .table_full_i      (table_full),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked),
    .full_seen_o       (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Stall length: mostly short, now and then a long one.
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Gap after an item; quiet stretches send back to back.
  function automatic int input_gap();
    int r;
    if (quiet_items > 0) begin
      quiet_items--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      quiet_items = $urandom_range(40, 120);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    return stall_len();
  endfunction

  function automatic logic [HW-1:0] rand_handle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return HW'($urandom_range(0, (1 << HW) - 1));
  endfunction

  // Result side stalls in bursts, with stretches of no stall at all.
  initial begin
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 9) < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        repeat ($urandom_range(5, 20)) begin
          out_stall <= 1'b1;
          repeat (stall_len()) @(posedge clk);
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_item(input logic [OP_WIDTH-1:0] op, input logic [SEQ_WIDTH-1:0] key,
                           input logic [HW-1:0] handle);
    int gap;
    in_valid        <= 1'b1;
    operation       <= op;
    sequence_number <= key;
    reply_in        <= handle;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = input_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int r;
    int directed_items;
    int waited;
    logic [OP_WIDTH-1:0]  op;
    logic [SEQ_WIDTH-1:0] key;
    logic                 fresh;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through every operation and the corner cases.
    send_item(OP_QUERY, 32'h0, 16'h0);                   // empty table
    send_item(OP_BEGIN_WAIT, 32'h0, 16'h0);
    send_item(OP_BEGIN_WAIT, 32'hFFFF_FFFF, 16'h0);
    send_item(OP_STORE_REPLY, 32'h0, 16'hFFFF);
    send_item(OP_BEGIN_WAIT, 32'h0, 16'h0);              // already answered: refused
    send_item(OP_STORE_REPLY, 32'h0, 16'h1234);          // second reply refused
    send_item(OP_QUERY, 32'h0, 16'h0);
    send_item(OP_TAKE_REPLY, 32'h0, 16'h0);
    send_item(OP_TAKE_REPLY, 32'h0, 16'h0);              // entry is gone
    send_item(OP_STORE_REPLY, 32'h5, 16'h5555);          // no such request
    send_item(OP_STORE_REPLY, 32'hFFFF_FFFF, 16'h0);
    send_item(OP_BEGIN_WAIT, 32'h7, 16'h0);
    send_item(OP_RECONNECT_CLEAR, 32'h7, 16'h0);         // drops answered, fails waiting
    send_item(OP_QUERY, 32'h7, 16'h0);
    send_item(OP_STORE_REPLY, 32'h7, 16'hA5A5);          // reply on a failed entry
    send_item(OP_QUERY, 32'h7, 16'h0);
    send_item(OP_TAKE_REPLY, 32'h7, 16'h0);
    send_item(OP_BEGIN_WAIT, 32'h9, 16'h0);
    send_item(OP_RECONNECT_CLEAR, 32'h9, 16'h0);
    send_item(OP_BEGIN_WAIT, 32'h9, 16'h0);              // restart clears the failed mark
    send_item(OP_ERASE, 32'h9, 16'h0);
    send_item(OP_ERASE, 32'h9, 16'h0);                   // erase with no match
    send_item(OP_RECONNECT_CLEAR, 32'h0, 16'h0);         // nothing in the table
    send_item(OP_SPARE_LO, 32'h5555_AAAA, 16'h0);
    send_item(OP_SPARE_HI, 32'hAAAA_5555, 16'h0);
    directed_items = items_sent;

    // Random part: mostly request lifecycles, with fills, drains and loose items.
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      if (r < 2) begin
        // Fill past capacity so begin wait meets a full table.
        for (int i = 0; i < KEY_POOL; i++) send_item(OP_BEGIN_WAIT, key_pool[i], rand_handle());
      end else if (r < 4) begin
        for (int i = 0; i < KEY_POOL; i++) send_item(OP_ERASE, key_pool[i], rand_handle());
      end else if (r < 55) begin
        send_item(OP_BEGIN_WAIT, key, rand_handle());
        if ($urandom_range(0, 99) < 80) send_item(OP_STORE_REPLY, key, rand_handle());
        if ($urandom_range(0, 99) < 70) send_item(OP_TAKE_REPLY, key, rand_handle());
        else if ($urandom_range(0, 99) < 30) send_item(OP_ERASE, key, rand_handle());
      end else begin
        fresh = ($urandom_range(0, 99) < 15);
        if (fresh) key = $urandom();
        r = $urandom_range(0, 99);
        if (r < 25)      op = OP_BEGIN_WAIT;
        else if (r < 45) op = OP_STORE_REPLY;
        else if (r < 63) op = OP_TAKE_REPLY;
        else if (r < 73) op = OP_ERASE;
        else if (r < 78) op = OP_RECONNECT_CLEAR;
        else if (r < 92) op = OP_QUERY;
        else if (r < 96) op = OP_SPARE_LO;
        else             op = OP_SPARE_HI;
        send_item(op, key, rand_handle());
        // A one-off key must not stay in the table for good.
        if (fresh && op == OP_BEGIN_WAIT) send_item(OP_ERASE, key, rand_handle());
      end
    end

    // Let every outstanding result drain, up to a drain limit, before the summary.
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d items and checked %0d results across all six operations and spare codes.",
             items_sent, checked);
    $display("Begin wait met a full table %0d times; %0d mismatches, %0d results outstanding.",
             full_seen, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
